@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the monitor RTL.
// Included by the modules that check their own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MPFM_ASSERT(lbl, clk, rst, prop) \
    lbl: assert property (@(posedge clk) disable iff (rst) prop) \
        else $error("%m: assertion failed");
`define MPFM_NEVER(lbl, clk, rst, cond) \
    lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
        else $error("%m: forbidden condition seen");
`else
`define MPFM_ASSERT(lbl, clk, rst, prop)
`define MPFM_NEVER(lbl, clk, rst, cond)
`endif
`endif

@@ hw/rtl/mpfm_pkg.sv @@
// Package for the mains presence and frequency monitor.
// Holds widths, register indexes, reset values and divider request types.
package mpfm_pkg;
    localparam int CHANNELS     = 4;
    localparam int CH_W         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int RESULT_LIMIT = 4;
    localparam int N_RES        = (CHANNELS < RESULT_LIMIT) ? CHANNELS : RESULT_LIMIT;
    localparam int TIME_W       = 32;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CNT_W        = 8;
    localparam int CHAN_FIELD_W = 2;
    localparam int DIV_STEP_W   = $clog2(CNT_W);

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic CMD_CROSS = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam logic [CFG_W-1:0] LOSS_TIMEOUT_RST  = 16'd100;
    localparam logic [CFG_W-1:0] WINDOW_LENGTH_RST = 16'd1000;
    localparam logic [CFG_W-1:0] WINDOW_GAP_RST    = 16'd10000;
    localparam logic [CNT_W-1:0] COUNT_DIVISOR_RST = 8'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOSS_TIMEOUT  = 2'd0,
        CFG_WINDOW_LENGTH = 2'd1,
        CFG_WINDOW_GAP    = 2'd2,
        CFG_COUNT_DIVISOR = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] quotient;
    } t_div_rsp;
endpackage

@@ hw/rtl/mpfm_if.sv @@
// Valid/ready channels of the monitor: input items and per-channel results.
// Depends on mpfm_pkg for field widths.
interface mpfm_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 cmd;
    logic [mpfm_pkg::CHAN_FIELD_W-1:0]    channel;
    logic [mpfm_pkg::TIME_W-1:0]          time_ms;

    modport source (output valid, cmd, channel, time_ms, input ready);
    modport sink   (input valid, cmd, channel, time_ms, output ready);
endinterface

interface mpfm_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [mpfm_pkg::CHAN_FIELD_W-1:0]    chan_index;
    logic                                 power_on;
    logic                                 status_changed;
    logic [mpfm_pkg::CNT_W-1:0]           frequency;
    logic                                 any_power;
    logic                                 measuring;
    logic                                 last_result;

    modport source (output valid, chan_index, power_on, status_changed, frequency,
                    any_power, measuring, last_result, input ready);
    modport sink   (input valid, chan_index, power_on, status_changed, frequency,
                    any_power, measuring, last_result, output ready);
endinterface

@@ hw/rtl/mpfm_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on mpfm_pkg (t_div_req, t_div_rsp) and assert_macros.svh.
`include "assert_macros.svh"

module mpfm_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mpfm_pkg::t_div_req i_req,
    output mpfm_pkg::t_div_rsp o_rsp
);
    logic                                r_busy;
    logic                                r_done;
    logic [mpfm_pkg::DIV_STEP_W-1:0]     r_step;
    logic [mpfm_pkg::CNT_W-1:0]          r_quo;
    logic [mpfm_pkg::CNT_W-1:0]          r_rem;
    logic [mpfm_pkg::CNT_W-1:0]          r_dvs;
    logic [mpfm_pkg::CNT_W-1:0]          r_dvd;

    logic [mpfm_pkg::CNT_W:0]            shifted;
    logic [mpfm_pkg::CNT_W:0]            trial;
    logic                                fits;

    always_comb begin
        shifted = {r_rem, r_quo[mpfm_pkg::CNT_W-1]};
        trial   = shifted - {1'b0, r_dvs};
        fits    = shifted >= {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_quo  <= i_req.dividend;
                r_dvd  <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= (i_req.divisor == '0) ? mpfm_pkg::CNT_W'(1) : i_req.divisor;
            end else if (r_busy) begin
                r_rem  <= fits ? trial[mpfm_pkg::CNT_W-1:0] : shifted[mpfm_pkg::CNT_W-1:0];
                r_quo  <= {r_quo[mpfm_pkg::CNT_W-2:0], fits};
                r_step <= r_step + mpfm_pkg::DIV_STEP_W'(1);
                if (r_step == mpfm_pkg::DIV_STEP_W'(mpfm_pkg::CNT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    `MPFM_ASSERT(a_done_after_busy, i_clk, !i_rst_n, o_rsp.done |-> $past(r_busy))
    `MPFM_NEVER(a_no_restart, i_clk, !i_rst_n, i_req.start && r_busy)
    `MPFM_ASSERT(a_quo_bounded, i_clk, !i_rst_n, o_rsp.done |-> (o_rsp.quotient <= r_dvd))
endmodule

@@ hw/rtl/mains_presence_freq_monitor.sv @@
// Mains presence and frequency monitor: sequencer, channel state and window timer.
// Depends on mpfm_pkg, mpfm_if (mpfm_in_if, mpfm_out_if), mpfm_div, assert_macros.svh.
//
// A crossing item is handled in the cycle it is accepted. A tick item runs the
// loss check for each channel in turn on the shared 32-bit subtract/compare
// unit, then delivers its results in turn, holding on output stalls; when the
// tick closes the counting window it first runs each channel's count through
// the shared 8-bit divider, one channel after another. The block takes no input
// item while a tick is in progress or its results are still being delivered.
`include "assert_macros.svh"

module mains_presence_freq_monitor (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mpfm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mpfm_pkg::CFG_W-1:0]        i_cfg_wdata,
    mpfm_in_if.sink                           i_in,
    mpfm_out_if.source                        o_out
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_ISSUE,
        S_DIV_WAIT,
        S_LOSS,
        S_EMIT
    } t_state;

    localparam int CHN = mpfm_pkg::CHANNELS;
    localparam int CHW = mpfm_pkg::CH_W;
    localparam int TW  = mpfm_pkg::TIME_W;
    localparam int CW  = mpfm_pkg::CFG_W;
    localparam int NW  = mpfm_pkg::CNT_W;

    t_state                r_state, n_state;
    logic [CHW-1:0]        r_idx, n_idx;
    logic [CW-1:0]         r_loss_to, r_win_len, r_win_gap;
    logic [NW-1:0]         r_divisor;
    logic [CHN-1:0]        r_power, n_power;
    logic [CHN-1:0]        r_reported, n_reported;
    logic [CHN-1:0]        r_changed, n_changed;
    logic [NW-1:0]         r_count [CHN];
    logic [NW-1:0]         n_count [CHN];
    logic [NW-1:0]         r_freq [CHN];
    logic [NW-1:0]         n_freq [CHN];
    logic [TW-1:0]         r_last [CHN];
    logic [TW-1:0]         n_last [CHN];
    logic                  r_win_open, n_win_open;
    logic [TW-1:0]         r_win_start, n_win_start;
    logic [TW-1:0]         r_win_end, n_win_end;
    logic [TW-1:0]         r_now, n_now;
    logic                  r_any, n_any;

    logic [TW-1:0]         sub_a, sub_b, sub_diff;
    logic [CW-1:0]         sub_lim;
    logic                  sub_ge;
    logic                  in_acc;
    logic [CHW-1:0]        cross_ch;
    logic                  cross_ok;
    logic                  drop;
    logic                  keep;

    mpfm_pkg::t_div_req    div_req;
    mpfm_pkg::t_div_rsp    div_rsp;

    mpfm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign div_req.start    = (r_state == S_DIV_ISSUE);
    assign div_req.dividend = r_count[r_idx];
    assign div_req.divisor  = r_divisor;

    always_comb begin
        if (r_state == S_IDLE) begin
            sub_a   = i_in.time_ms;
            sub_b   = r_win_open ? r_win_start : r_win_end;
            sub_lim = r_win_open ? r_win_len : r_win_gap;
        end else begin
            sub_a   = r_now;
            sub_b   = r_last[r_idx];
            sub_lim = r_loss_to;
        end
        sub_diff = sub_a - sub_b;
        sub_ge   = sub_diff >= {{(TW - CW){1'b0}}, sub_lim};
    end

    assign in_acc   = i_in.valid && i_in.ready;
    assign cross_ch = CHW'(i_in.channel);
    assign cross_ok = 32'(i_in.channel) < CHN;
    assign drop     = r_power[r_idx] && (r_last[r_idx] != '0) && (r_last[r_idx] < r_now)
                      && sub_ge;
    assign keep     = r_power[r_idx] && !drop;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_power     = r_power;
        n_reported  = r_reported;
        n_changed   = r_changed;
        n_count     = r_count;
        n_freq      = r_freq;
        n_last      = r_last;
        n_win_open  = r_win_open;
        n_win_start = r_win_start;
        n_win_end   = r_win_end;
        n_now       = r_now;
        n_any       = r_any;
        case (r_state)
            S_IDLE: begin
                if (in_acc && i_in.cmd == mpfm_pkg::CMD_CROSS) begin
                    if (cross_ok) begin
                        if (r_win_open && r_count[cross_ch] != mpfm_pkg::CNT_MAX) begin
                            n_count[cross_ch] = r_count[cross_ch] + NW'(1);
                        end
                        n_last[cross_ch]  = i_in.time_ms;
                        n_power[cross_ch] = 1'b1;
                    end
                end else if (in_acc) begin
                    n_now = i_in.time_ms;
                    n_idx = '0;
                    n_any = 1'b0;
                    n_state = S_LOSS;
                    if (r_win_open) begin
                        if (sub_ge) begin
                            n_win_open  = 1'b0;
                            n_win_end   = i_in.time_ms;
                            n_win_start = '0;
                            n_state     = S_DIV_ISSUE;
                        end
                    end else if (sub_ge) begin
                        n_win_open  = 1'b1;
                        n_win_start = i_in.time_ms;
                    end
                end
            end
            S_DIV_ISSUE: begin
                n_state = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_rsp.done) begin
                    n_freq[r_idx]  = div_rsp.quotient;
                    n_count[r_idx] = '0;
                    if (r_idx == CHW'(CHN - 1)) begin
                        n_idx   = '0;
                        n_state = S_LOSS;
                    end else begin
                        n_idx   = r_idx + CHW'(1);
                        n_state = S_DIV_ISSUE;
                    end
                end
            end
            S_LOSS: begin
                n_power[r_idx]    = keep;
                n_changed[r_idx]  = r_reported[r_idx] != keep;
                n_reported[r_idx] = keep;
                n_any             = r_any || keep;
                if (drop) begin
                    n_last[r_idx] = '0;
                end
                if (r_idx == CHW'(CHN - 1)) begin
                    n_idx   = '0;
                    n_state = S_EMIT;
                end else begin
                    n_idx = r_idx + CHW'(1);
                end
            end
            S_EMIT: begin
                if (o_out.ready) begin
                    if (r_idx == CHW'(mpfm_pkg::N_RES - 1)) begin
                        n_idx   = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + CHW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_loss_to   <= mpfm_pkg::LOSS_TIMEOUT_RST;
            r_win_len   <= mpfm_pkg::WINDOW_LENGTH_RST;
            r_win_gap   <= mpfm_pkg::WINDOW_GAP_RST;
            r_divisor   <= mpfm_pkg::COUNT_DIVISOR_RST;
            r_power     <= '0;
            r_reported  <= '0;
            r_changed   <= '0;
            r_count     <= '{default: '0};
            r_freq      <= '{default: '0};
            r_last      <= '{default: '0};
            r_win_open  <= 1'b0;
            r_win_start <= '0;
            r_win_end   <= '0;
            r_any       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_power     <= n_power;
            r_reported  <= n_reported;
            r_changed   <= n_changed;
            r_count     <= n_count;
            r_freq      <= n_freq;
            r_last      <= n_last;
            r_win_open  <= n_win_open;
            r_win_start <= n_win_start;
            r_win_end   <= n_win_end;
            r_any       <= n_any;
            if (i_cfg_we) begin
                case (mpfm_pkg::t_cfg_idx'(i_cfg_idx))
                    mpfm_pkg::CFG_LOSS_TIMEOUT:  r_loss_to <= i_cfg_wdata;
                    mpfm_pkg::CFG_WINDOW_LENGTH: r_win_len <= i_cfg_wdata;
                    mpfm_pkg::CFG_WINDOW_GAP:    r_win_gap <= i_cfg_wdata;
                    mpfm_pkg::CFG_COUNT_DIVISOR: r_divisor <= i_cfg_wdata[NW-1:0];
                    default: begin
                    end
                endcase
            end
        end
        r_now <= n_now;
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = (r_state == S_EMIT);
    assign o_out.chan_index     = mpfm_pkg::CHAN_FIELD_W'(r_idx);
    assign o_out.power_on       = r_power[r_idx];
    assign o_out.status_changed = r_changed[r_idx];
    assign o_out.frequency      = r_freq[r_idx];
    assign o_out.any_power      = r_any;
    assign o_out.measuring      = r_win_open;
    assign o_out.last_result    = (r_idx == CHW'(mpfm_pkg::N_RES - 1));

    `MPFM_NEVER(a_no_overlap, i_clk, !i_rst_n, i_in.ready && o_out.valid)
    `MPFM_ASSERT(a_last_frees, i_clk, !i_rst_n, (o_out.valid && o_out.ready && o_out.last_result) |=> i_in.ready)
    `MPFM_ASSERT(a_any_power, i_clk, !i_rst_n, o_out.valid |-> (o_out.any_power == (|r_power)))
    `MPFM_ASSERT(a_div_done_wait, i_clk, !i_rst_n, div_rsp.done |-> (r_state == S_DIV_WAIT))
endmodule
